/* rtl/icdf_pkg.sv */
// Shared types, constants and helper functions for the inverse-CDF table sampler.
`timescale 1ns / 1ps
`default_nettype none
package icdf_pkg;

  // Payload widths
  localparam int ENTRY_INDEX_W = 10;
  localparam int CDF_W         = 32;
  localparam int RADIUS_W      = 32;
  localparam int POINTS_W      = 11;

  // Default table depth
  localparam int TABLE_DEPTH_DEF = 1024;

  // Configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam int REG_SEL_W = 2;
  localparam logic [REG_SEL_W-1:0] REG_RADIUS_START = 2'd0;
  localparam logic [REG_SEL_W-1:0] REG_RADIUS_STEP  = 2'd1;
  localparam logic [REG_SEL_W-1:0] REG_POINTS       = 2'd2;

  localparam logic [RADIUS_W-1:0] RADIUS_START_RST = 32'd50331648;
  localparam logic [RADIUS_W-1:0] RADIUS_STEP_RST  = 32'd196800;
  localparam logic [POINTS_W-1:0] POINTS_RST       = 11'd1024;

  // Item modes
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // Serial divider: 64-bit dividend, 32-bit divisor, two quotient bits a cycle
  localparam int DIVIDEND_W = 64;
  localparam int DIVISOR_W  = 32;
  localparam int DIV_CYCLES = DIVIDEND_W / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

  // One restoring step: shift in a dividend bit, subtract if it fits.
  // Returns {new remainder, quotient bit}. Requires rem < den.
  function automatic logic [DIVISOR_W:0] div_step(input logic [DIVISOR_W-1:0] rem,
                                                 input logic                 bit_in,
                                                 input logic [DIVISOR_W-1:0] den);
    logic [DIVISOR_W:0] t;
    logic [DIVISOR_W:0] diff;
    t    = {rem, bit_in};
    diff = t - {1'b0, den};
    if (t >= {1'b0, den}) begin
      return {diff[DIVISOR_W-1:0], 1'b1};
    end
    return {t[DIVISOR_W-1:0], 1'b0};
  endfunction

endpackage
`default_nettype wire

/* rtl/icdf_table.sv */
// CDF table memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module icdf_table #(
  parameter int TABLE_DEPTH = icdf_pkg::TABLE_DEPTH_DEF,
  parameter int AW          = $clog2(TABLE_DEPTH)
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [AW-1:0]            wr_addr,
  input  wire logic [icdf_pkg::CDF_W-1:0] wr_data,
  input  wire logic [AW-1:0]            rd_addr,
  output logic      [icdf_pkg::CDF_W-1:0] rd_data
);

  logic [icdf_pkg::CDF_W-1:0] mem [TABLE_DEPTH];
  logic [icdf_pkg::CDF_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

/* rtl/icdf_divider.sv */
// Radix-4 restoring divider, 64/32 bits.
`timescale 1ns / 1ps
`default_nettype none
module icdf_divider (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire icdf_pkg::div_req_t req,
  output icdf_pkg::div_rsp_t      rsp
);

  logic                                run_r, run_nxt;
  logic                                done_r, done_nxt;
  logic [icdf_pkg::DIV_CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [icdf_pkg::DIVISOR_W-1:0]      rem_r, rem_nxt;
  logic [icdf_pkg::DIVISOR_W-1:0]      den_r, den_nxt;
  logic [icdf_pkg::DIVIDEND_W-1:0]     quo_r, quo_nxt;
  logic [icdf_pkg::DIVISOR_W:0]        step1;
  logic [icdf_pkg::DIVISOR_W:0]        step2;

  // Dividend bits leave the top of quo_r, quotient bits enter at the bottom
  assign step1 = icdf_pkg::div_step(rem_r, quo_r[icdf_pkg::DIVIDEND_W-1], den_r);
  assign step2 = icdf_pkg::div_step(step1[icdf_pkg::DIVISOR_W:1],
                                    quo_r[icdf_pkg::DIVIDEND_W-2], den_r);

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      rem_nxt = '0;
      den_nxt = req.divisor;
      quo_nxt = req.dividend;
    end else if (run_r) begin
      rem_nxt = step2[icdf_pkg::DIVISOR_W:1];
      quo_nxt = {quo_r[icdf_pkg::DIVIDEND_W-3:0], step1[0], step2[0]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == icdf_pkg::DIV_CNT_W'(icdf_pkg::DIV_CYCLES - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule
`default_nettype wire

/* rtl/inverse_cdf_table_sampler.sv */
// Top level: inverse-CDF radius sampler, sequencer, shared multiplier and config registers.
//
//  channel | handshake                          | payload
//  --------+------------------------------------+------------------------------------------
//  input   | start / busy, beat at start&!busy  | in_mode, in_entry_index, in_entry_cdf,
//          |                                    | in_uniform_draw
//  result  | out_valid, one-cycle strobe        | out_is_sample, out_radius
//  config  | APB psel/penable/pwrite, pready=1  | paddr, pwdata, prdata
//
//  A load beat keeps busy low; its acknowledge strobes the next cycle.
//  A sample beat holds busy high through a binary search over n entries (n = points
//  in use, clamped), each probe a read through the single table read port, two
//  reads for the interval ends, two products on the one 32x32 multiplier, and
//  the radix-4 divider for the interpolation fraction unless the interval is flat or falling.
//  Synchronous active-low reset clears the sequencer and config registers; the
//  table is not cleared. The receiver cannot stall; a result is shown once.
`timescale 1ns / 1ps
`default_nettype none
module inverse_cdf_table_sampler #(
  parameter int TABLE_DEPTH = icdf_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // input channel
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic                                  in_mode,
  input  wire logic [icdf_pkg::ENTRY_INDEX_W-1:0]    in_entry_index,
  input  wire logic [icdf_pkg::CDF_W-1:0]            in_entry_cdf,
  input  wire logic [icdf_pkg::CDF_W-1:0]            in_uniform_draw,
  // result channel
  output logic                                       out_valid,
  output logic                                       out_is_sample,
  output logic      [icdf_pkg::RADIUS_W-1:0]         out_radius,
  // config port
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [icdf_pkg::PADDR_W-1:0]          paddr,
  input  wire logic [icdf_pkg::PDATA_W-1:0]          pwdata,
  output logic      [icdf_pkg::PDATA_W-1:0]          prdata,
  output logic                                       pready
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);   // holds 0..TABLE_DEPTH
  localparam int BW = AW + 33;                   // start + (idx-1)*step, exact
  localparam int RW = icdf_pkg::RADIUS_W;
  localparam int DW = icdf_pkg::CDF_W;
  localparam int QW = icdf_pkg::DIVIDEND_W;

  // sequencer states
  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_SRCH_RD  = 4'd1;  // issue probe read
  localparam logic [3:0] ST_SRCH_CMP = 4'd2;  // narrow the search window
  localparam logic [3:0] ST_LO_RD    = 4'd3;  // read entry idx-1, (idx-1)*step
  localparam logic [3:0] ST_HI_RD    = 4'd4;  // read entry idx, form base
  localparam logic [3:0] ST_HI_CAP   = 4'd5;  // capture hi, |d|*step
  localparam logic [3:0] ST_CHK      = 4'd6;  // flat interval or start divide
  localparam logic [3:0] ST_DIV      = 4'd7;
  localparam logic [3:0] ST_FIN      = 4'd8;

  // ---------------------------------------------------------------- config
  logic [RW-1:0]                    radius_start_r;
  logic [RW-1:0]                    radius_step_r;
  logic [icdf_pkg::POINTS_W-1:0]    points_r;
  logic                             cfg_wr;
  logic [icdf_pkg::REG_SEL_W-1:0]   reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[icdf_pkg::REG_SEL_W+1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_start_r <= icdf_pkg::RADIUS_START_RST;
      radius_step_r  <= icdf_pkg::RADIUS_STEP_RST;
      points_r       <= icdf_pkg::POINTS_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        icdf_pkg::REG_RADIUS_START: radius_start_r <= pwdata;
        icdf_pkg::REG_RADIUS_STEP:  radius_step_r  <= pwdata;
        icdf_pkg::REG_POINTS:       points_r       <= pwdata[icdf_pkg::POINTS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      icdf_pkg::REG_RADIUS_START: prdata = radius_start_r;
      icdf_pkg::REG_RADIUS_STEP:  prdata = radius_step_r;
      icdf_pkg::REG_POINTS:       prdata = icdf_pkg::PDATA_W'(points_r);
      default:                    prdata = '0;
    endcase
  end

  // points in use, clamped to 2..TABLE_DEPTH
  logic [31:0]   points_ext;
  logic [CW-1:0] n_cfg;

  assign points_ext = 32'(points_r);

  always_comb begin
    priority if (points_ext < 32'd2) begin
      n_cfg = CW'(2);
    end else if (points_ext > 32'(TABLE_DEPTH)) begin
      n_cfg = CW'(TABLE_DEPTH);
    end else begin
      n_cfg = CW'(points_ext);
    end
  end

  // ---------------------------------------------------------------- state
  logic [3:0]     state_r, state_nxt;
  logic [CW-1:0]  n_r, n_nxt;
  logic [CW-1:0]  first_r, first_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [AW-1:0]  idx_r, idx_nxt;
  logic [DW-1:0]  draw_r, draw_nxt;
  logic [DW-1:0]  lo_r, lo_nxt;
  logic [DW-1:0]  hi_r, hi_nxt;
  logic           up_r, up_nxt;
  logic [QW-1:0]  mul_p_r, mul_p_nxt;
  logic [BW-1:0]  base_r, base_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_is_sample_r, out_is_sample_nxt;
  logic [RW-1:0]  out_radius_r, out_radius_nxt;

  logic           accept;
  logic [CW-1:0]  half;
  logic [CW-1:0]  probe;
  logic [AW-1:0]  idx_m1;
  logic [CW-1:0]  first_clamped;
  logic [DW-1:0]  rd_data;
  logic [AW-1:0]  rd_addr;
  logic           wr_en;
  logic [31:0]    wr_index_ext;
  logic [31:0]    mul_a;
  logic [DW-1:0]  mag;
  logic           draw_ge_lo;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start & ~busy;

  assign half   = count_r >> 1;
  assign probe  = first_r + half;
  assign idx_m1 = idx_r - AW'(1);

  // found index clamped to 1..n-1
  always_comb begin
    priority if (first_r == '0) begin
      first_clamped = CW'(1);
    end else if (first_r > n_r - CW'(1)) begin
      first_clamped = n_r - CW'(1);
    end else begin
      first_clamped = first_r;
    end
  end

  // table ports; loads beyond the table are acknowledged but dropped
  assign wr_index_ext = 32'(in_entry_index);
  assign wr_en        = accept & (in_mode == icdf_pkg::MODE_LOAD)
                        & (wr_index_ext < 32'(TABLE_DEPTH));

  always_comb begin
    unique case (state_r)
      ST_LO_RD: rd_addr = idx_m1;
      ST_HI_RD: rd_addr = idx_r;
      default:  rd_addr = AW'(probe);
    endcase
  end

  icdf_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_index_ext[AW-1:0]),
    .wr_data (in_entry_cdf),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // shared 32x32 multiplier, second operand is always the grid step
  assign draw_ge_lo = (draw_r >= lo_r);
  assign mag        = draw_ge_lo ? (draw_r - lo_r) : (lo_r - draw_r);
  assign mul_a      = (state_r == ST_LO_RD) ? 32'(idx_m1) : mag;

  // divider
  icdf_pkg::div_req_t div_req;
  icdf_pkg::div_rsp_t div_rsp;

  assign div_req.start    = (state_r == ST_CHK) & (hi_r > lo_r);
  assign div_req.dividend = mul_p_r;
  assign div_req.divisor  = hi_r - lo_r;

  icdf_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // final radius: base +/- quotient, saturated to 0..2^32-1
  logic [BW:0]    sum_up;
  logic [BW-1:0]  diff_dn;
  logic [RW-1:0]  base_sat;
  logic [RW-1:0]  fin_radius;

  assign sum_up   = (BW+1)'(base_r) + (BW+1)'(div_rsp.quotient[RW-1:0]);
  assign diff_dn  = base_r - div_rsp.quotient[BW-1:0];
  assign base_sat = (|base_r[BW-1:RW]) ? '1 : base_r[RW-1:0];

  always_comb begin
    if (up_r) begin
      if (|div_rsp.quotient[QW-1:RW]) begin
        fin_radius = '1;
      end else if (|sum_up[BW:RW]) begin
        fin_radius = '1;
      end else begin
        fin_radius = sum_up[RW-1:0];
      end
    end else begin
      if (div_rsp.quotient >= QW'(base_r)) begin
        fin_radius = '0;
      end else if (|diff_dn[BW-1:RW]) begin
        fin_radius = '1;
      end else begin
        fin_radius = diff_dn[RW-1:0];
      end
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt         = state_r;
    n_nxt             = n_r;
    first_nxt         = first_r;
    count_nxt         = count_r;
    idx_nxt           = idx_r;
    draw_nxt          = draw_r;
    lo_nxt            = lo_r;
    hi_nxt            = hi_r;
    up_nxt            = up_r;
    mul_p_nxt         = mul_p_r;
    base_nxt          = base_r;
    out_valid_nxt     = 1'b0;
    out_is_sample_nxt = out_is_sample_r;
    out_radius_nxt    = out_radius_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_mode == icdf_pkg::MODE_LOAD) begin
            out_valid_nxt     = 1'b1;
            out_is_sample_nxt = 1'b0;
            out_radius_nxt    = '0;
          end else begin
            draw_nxt  = in_uniform_draw;
            n_nxt     = n_cfg;
            first_nxt = '0;
            count_nxt = n_cfg;
            state_nxt = ST_SRCH_RD;
          end
        end
      end
      ST_SRCH_RD: begin
        if (count_r == '0) begin
          idx_nxt   = AW'(first_clamped);
          state_nxt = ST_LO_RD;
        end else begin
          state_nxt = ST_SRCH_CMP;
        end
      end
      ST_SRCH_CMP: begin
        if (rd_data < draw_r) begin
          first_nxt = probe + CW'(1);
          count_nxt = count_r - half - CW'(1);
        end else begin
          count_nxt = half;
        end
        state_nxt = ST_SRCH_RD;
      end
      ST_LO_RD: begin
        mul_p_nxt = mul_a * radius_step_r;
        state_nxt = ST_HI_RD;
      end
      ST_HI_RD: begin
        lo_nxt    = rd_data;
        base_nxt  = BW'(radius_start_r) + BW'(mul_p_r[AW+RW-1:0]);
        state_nxt = ST_HI_CAP;
      end
      ST_HI_CAP: begin
        hi_nxt    = rd_data;
        up_nxt    = draw_ge_lo;
        mul_p_nxt = mul_a * radius_step_r;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (hi_r <= lo_r) begin
          // flat or falling interval: lower grid radius
          out_valid_nxt     = 1'b1;
          out_is_sample_nxt = 1'b1;
          out_radius_nxt    = base_sat;
          state_nxt         = ST_IDLE;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        out_valid_nxt     = 1'b1;
        out_is_sample_nxt = 1'b1;
        out_radius_nxt    = fin_radius;
        state_nxt         = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      first_r     <= '0;
      count_r     <= '0;
      n_r         <= CW'(2);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      first_r     <= first_nxt;
      count_r     <= count_nxt;
      n_r         <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r           <= idx_nxt;
    draw_r          <= draw_nxt;
    lo_r            <= lo_nxt;
    hi_r            <= hi_nxt;
    up_r            <= up_nxt;
    mul_p_r         <= mul_p_nxt;
    base_r          <= base_nxt;
    out_is_sample_r <= out_is_sample_nxt;
    out_radius_r    <= out_radius_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_is_sample = out_is_sample_r;
  assign out_radius    = out_radius_r;

  // ---------------------------------------------------------------- checks
  a_load_ack: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_mode == icdf_pkg::MODE_LOAD)
      |=> out_valid && !out_is_sample && (out_radius == '0) && !busy)
    else $error("load beat not acknowledged in the next cycle");

  a_sample_holds: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_mode == icdf_pkg::MODE_SAMPLE) |=> busy && !out_valid)
    else $error("sample beat did not keep the block busy");

  a_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SRCH_RD || state_r == ST_SRCH_CMP)
      |-> ({1'b0, first_r} + {1'b0, count_r}) <= {1'b0, n_r})
    else $error("search window ran past the points in use");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LO_RD) |-> (idx_r != '0) && (CW'(idx_r) < n_r))
    else $error("interpolation index outside 1..n-1");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide state");

endmodule
`default_nettype wire

/* sim/testbench.sv */
// Testbench for the inverse-CDF table sampler: table loads and radius samples checked beat by beat.
`timescale 1ns / 1ps
module testbench;
  import icdf_pkg::*;

  localparam int DEPTH         = TABLE_DEPTH_DEF;
  localparam int RANDOM_BEATS  = 850;
  localparam int PHASES        = 9;
  // settle time, longer than the longest sample beat with margin
  localparam int SETTLE_CYCLES = 80;
  // several times the slowest run of all planned beats with their gaps
  localparam int CYCLE_LIMIT   = 1_000_000;

  // one input beat, every field carried even when the mode ignores it
  typedef struct packed {
    logic                     mode;
    logic [ENTRY_INDEX_W-1:0] pos;
    logic [CDF_W-1:0]         cdf;
    logic [CDF_W-1:0]         draw;
  } beat_t;

  // one result beat as the block should show it
  typedef struct packed {
    logic                is_sample;
    logic [RADIUS_W-1:0] radius;
  } radius_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     in_mode = MODE_LOAD;
  logic [ENTRY_INDEX_W-1:0] in_entry_index = '0;
  logic [CDF_W-1:0]         in_entry_cdf = '0;
  logic [CDF_W-1:0]         in_uniform_draw = '0;
  logic                     out_valid;
  logic                     out_is_sample;
  logic [RADIUS_W-1:0]      out_radius;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [PADDR_W-1:0]       paddr = '0;
  logic [PDATA_W-1:0]       pwdata = '0;
  logic [PDATA_W-1:0]       prdata;
  logic                     pready;

  inverse_cdf_table_sampler #(.TABLE_DEPTH(DEPTH)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_entry_index  (in_entry_index),
    .in_entry_cdf    (in_entry_cdf),
    .in_uniform_draw (in_uniform_draw),
    .out_valid       (out_valid),
    .out_is_sample   (out_is_sample),
    .out_radius      (out_radius),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: the table and registers as the block should hold them.
  // Updated only when a beat or a register write actually lands.
  // ---------------------------------------------------------------------------
  logic [CDF_W-1:0]    cdf_shadow [DEPTH];
  logic [RADIUS_W-1:0] start_radius = RADIUS_START_RST;
  logic [RADIUS_W-1:0] step_radius  = RADIUS_STEP_RST;
  logic [POINTS_W-1:0] points_reg   = POINTS_RST;

  // Stimulus-side view of the table, ahead of the block by whatever is still queued.
  logic [CDF_W-1:0]    planned_cdf [DEPTH];
  int unsigned         planned_points = DEPTH;

  beat_t       pending_beats [$];
  radius_t     radius_expect [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // driver bookkeeping, shared with the acceptance logic in the monitor
  beat_t       staged;
  logic        holding = 1'b0;
  logic        beat_taken = 1'b0;
  int unsigned gap_left = 0;
  int unsigned calm_run = 0;

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("MISMATCH at %0t: %s got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // register value below 2 acts as 2, above the depth acts as the depth
  function automatic int unsigned live_points(input logic [POINTS_W-1:0] raw);
    if (raw < 2) return 2;
    if (raw > DEPTH) return DEPTH;
    return raw;
  endfunction

  function automatic logic [RADIUS_W-1:0] saturate(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? '1 : v[31:0];
  endfunction

  // Lower-bound search over the live entries, index clamped to 1..n-1, then
  // linear interpolation (or extrapolation) on the radius grid.
  function automatic logic [RADIUS_W-1:0] predict_radius(input logic [CDF_W-1:0] draw);
    int unsigned n, first, span, half, probe, idx;
    logic [CDF_W-1:0] lo, hi, mag;
    logic [63:0] base, q;
    n = live_points(points_reg);
    first = 0;
    span = n;
    while (span > 0) begin
      half = span / 2;
      probe = first + half;
      if (cdf_shadow[probe] < draw) begin
        first = probe + 1;
        span = span - half - 1;
      end else begin
        span = half;
      end
    end
    idx = (first < 1) ? 1 : (first > n - 1) ? n - 1 : first;
    lo = cdf_shadow[idx - 1];
    hi = cdf_shadow[idx];
    base = 64'(start_radius) + 64'(idx - 1) * 64'(step_radius);
    // flat or falling interval: lower grid radius
    if (hi <= lo) return saturate(base);
    mag = (draw >= lo) ? draw - lo : lo - draw;
    q = 64'(mag) * 64'(step_radius) / 64'(hi - lo);
    if (draw >= lo) begin
      if (q > 64'hFFFF_FFFF) return '1;
      return saturate(base + q);
    end
    // draw below the interval: extrapolate downward, floor at zero
    return (q >= base) ? '0 : saturate(base - q);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued beats at the falling edge. Each beat waits a drawn
  // number of cycles first; now and then a run of back-to-back beats.
  // start stays high across consecutive beats, it is never dropped and raised
  // again in one step.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (beat_taken) begin
        beat_taken = 1'b0;
        holding = 1'b0;
      end
      if (!holding && pending_beats.size() != 0) begin
        staged = pending_beats.pop_front();
        holding = 1'b1;
        if (calm_run != 0) begin
          calm_run--;
          gap_left = 0;
        end else begin
          gap_left = $urandom_range(0, 11);
          if ($urandom_range(0, 19) == 0) calm_run = $urandom_range(10, 40);
        end
      end
      if (holding && gap_left == 0) begin
        start           <= 1'b1;
        in_mode         <= staged.mode;
        in_entry_index  <= staged.pos;
        in_entry_cdf    <= staged.cdf;
        in_uniform_draw <= staged.draw;
      end else begin
        start <= 1'b0;
        if (holding) gap_left--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: at each rising edge, score a result strobe against the oldest
  // expectation, then predict for a beat the block takes at this same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    radius_t want;
    if (rst_n) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        if (out_valid === 1'b1) begin
          if (radius_expect.size() == 0) begin
            flag_mismatch("result with nothing pending", out_radius, '0);
          end else begin
            want = radius_expect.pop_front();
            if (out_is_sample !== want.is_sample)
              flag_mismatch("is_sample", 32'(out_is_sample), 32'(want.is_sample));
            if (out_radius !== want.radius)
              flag_mismatch("radius", out_radius, want.radius);
          end
        end
        if (start && busy === 1'b0) begin
          if (in_mode == MODE_LOAD) begin
            // every 10-bit index is inside a 1024-deep table
            cdf_shadow[in_entry_index] = in_entry_cdf;
            want.is_sample = 1'b0;
            want.radius = '0;
          end else begin
            want.is_sample = 1'b1;
            want.radius = predict_radius(in_uniform_draw);
          end
          radius_expect.push_back(want);
          beat_taken = 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic plan_load(input int unsigned pos, input logic [CDF_W-1:0] cdf);
    beat_t b;
    b.mode = MODE_LOAD;
    b.pos  = ENTRY_INDEX_W'(pos);
    b.cdf  = cdf;
    b.draw = $urandom;
    planned_cdf[pos] = cdf;
    pending_beats.push_back(b);
  endtask

  task automatic plan_sample(input logic [CDF_W-1:0] draw);
    beat_t b;
    b.mode = MODE_SAMPLE;
    b.pos  = ENTRY_INDEX_W'($urandom_range(0, DEPTH - 1));
    b.cdf  = $urandom;
    b.draw = draw;
    pending_beats.push_back(b);
  endtask

  // Well-formed table: nondecreasing from a small start, with some flat
  // steps; the top entry is forced to one when asked.
  task automatic plan_cdf_fill(input int unsigned n, input bit reach_one);
    logic [63:0] level, stride;
    int unsigned k;
    level = ($urandom_range(0, 3) == 0) ? 64'd0 : 64'($urandom_range(1, 32'h00FF_FFFF));
    stride = (64'hFFFF_FFFF - level) / n;
    for (k = 0; k < n; k++) begin
      if (k == n - 1 && reach_one) level = 64'hFFFF_FFFF;
      plan_load(k, saturate(level));
      if ($urandom_range(0, 9) != 0) level += 64'($urandom_range(0, 32'(stride))) * 2;
    end
  endtask

  // Mostly samples aimed at the live table, some order-keeping loads and a
  // little noise that breaks the ordering.
  task automatic plan_random(input int unsigned beats);
    int unsigned k, last;
    logic [CDF_W-1:0] lo, hi;
    repeat (beats) begin
      last = planned_points - 1;
      k = $urandom_range(0, last);
      case ($urandom_range(0, 19))
        0, 1, 2, 3: begin
          lo = (k == 0) ? '0 : planned_cdf[k - 1];
          hi = (k == last) ? '1 : planned_cdf[k + 1];
          plan_load(k, $urandom_range(lo, hi));
        end
        4: begin
          case ($urandom_range(0, 2))
            0:       plan_load($urandom_range(0, DEPTH - 1), $urandom);
            1:       plan_load($urandom_range(0, DEPTH - 1), '0);
            default: plan_load($urandom_range(0, DEPTH - 1), '1);
          endcase
        end
        default: begin
          case ($urandom_range(0, 7))
            0, 1, 2: plan_sample($urandom);
            3:       plan_sample(planned_cdf[k]);
            4:       plan_sample(planned_cdf[k] + 32'($urandom_range(0, 64)) - 32'd32);
            5:       plan_sample($urandom_range(planned_cdf[k],
                                                planned_cdf[(k == last) ? k : k + 1]));
            6: begin
              case ($urandom_range(0, 3))
                0:       plan_sample('0);
                1:       plan_sample(32'd1);
                2:       plan_sample(32'hFFFF_FFFE);
                default: plan_sample('1);
              endcase
            end
            default: begin
              // outside the first or last interval: extrapolation and saturation
              if ($urandom_range(0, 1) == 0) plan_sample($urandom_range(0, planned_cdf[0]));
              else plan_sample($urandom_range(planned_cdf[last], 32'hFFFF_FFFF));
            end
          endcase
        end
      endcase
    end
  endtask

  // APB write, then read back what the register should now hold
  task automatic write_register(input logic [REG_SEL_W-1:0] sel,
                                input logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] stored;
    stored = (sel == REG_POINTS) ? PDATA_W'(value[POINTS_W-1:0]) : value;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== stored) flag_mismatch("register readback", prdata, stored);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (sel)
      REG_RADIUS_START: start_radius = value;
      REG_RADIUS_STEP:  step_radius = value;
      default:          points_reg = value[POINTS_W-1:0];
    endcase
    planned_points = live_points(points_reg);
  endtask

  // everything queued has been taken and answered, then let the block settle
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_beats.size() != 0 || holding || radius_expect.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [CDF_W-1:0]    keep;
    logic [RADIUS_W-1:0] new_start, new_step;
    logic [PDATA_W-1:0]  new_points;
    int unsigned ph;

    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // Reset registers. Write the whole table first so no sample ever reads
    // an unwritten entry; the top stays below one for upward extrapolation.
    plan_cdf_fill(DEPTH, 1'b0);

    // directed: corner draws, exact hits, just below the first entry
    plan_sample('0);
    plan_sample('1);
    plan_sample(32'd1);
    plan_sample(32'h8000_0000);
    plan_sample(planned_cdf[0]);
    plan_sample(planned_cdf[511]);
    plan_sample(planned_cdf[DEPTH - 1]);
    plan_sample(planned_cdf[0] - 32'd1);
    // flat first interval: clamped index 1 with equal ends gives grid point zero
    keep = planned_cdf[1];
    plan_load(1, planned_cdf[0]);
    plan_sample('0);
    plan_load(1, keep);
    // falling last interval: draw past the end, clamped, returns the lower radius
    plan_load(DEPTH - 1, '0);
    plan_sample('1);
    plan_load(DEPTH - 1, '1);
    plan_sample('1);
    plan_sample(32'hFFFF_FFFE);
    plan_load(0, '0);
    plan_sample('0);
    plan_random(RANDOM_BEATS / PHASES);

    // register settings, extremes included; points outside 2..depth as well
    for (ph = 1; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        1: begin new_start = '0;            new_step = '0;
                 new_points = 0;                         end
        2: begin new_start = '1;            new_step = '1;
                 new_points = 1;                         end
        3: begin new_start = $urandom;      new_step = $urandom_range(0, 32'h00FF_FFFF);
                 new_points = 16;                        end
        4: begin new_start = '0;            new_step = '1;
                 new_points = 2047;                      end
        5: begin new_start = 32'h0100_0000; new_step = 32'h0001_0000;
                 new_points = 1025;                      end
        6: begin new_start = $urandom;      new_step = $urandom;
                 new_points = $urandom_range(2, DEPTH);  end
        7: begin new_start = 32'h7FFF_FFFF; new_step = 32'd1;
                 new_points = 3;                         end
        default: begin new_start = RADIUS_START_RST; new_step = RADIUS_STEP_RST;
                 new_points = PDATA_W'(POINTS_RST);     end
      endcase
      write_register(REG_RADIUS_START, new_start);
      write_register(REG_RADIUS_STEP, new_step);
      write_register(REG_POINTS, new_points);
      @(posedge clk);
      // small tables get a fresh ordered fill so samples explore real intervals
      if (planned_points <= 64) plan_cdf_fill(planned_points, $urandom_range(0, 1));
      plan_random(RANDOM_BEATS / PHASES);
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
